FILE: rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// shared types, constants and calendar helpers for the calendar clock
// ----------------------------------------------------------------------------
package cct_pkg;

	typedef logic [5:0] sec_t;
	typedef logic [5:0] min_t;
	typedef logic [4:0] hour_t;
	typedef logic [4:0] day_t;
	typedef logic [3:0] month_t;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	localparam sec_t   SEC_LAST   = 6'd59;
	localparam sec_t   SEC_LIMIT  = 6'd60;
	localparam min_t   MIN_LAST   = 6'd59;
	localparam min_t   MIN_LIMIT  = 6'd60;
	localparam hour_t  HOUR_LAST  = 5'd23;
	localparam hour_t  HOUR_LIMIT = 5'd24;
	localparam month_t MONTH_JAN  = 4'd1;
	localparam month_t MONTH_FEB  = 4'd2;
	localparam month_t MONTH_DEC  = 4'd12;
	localparam day_t   DAY_FIRST  = 5'd1;
	localparam day_t   DAY_LEAP_FEB = 5'd29;

	localparam int unsigned DEFAULT_YEAR = 2000;

	// modular inverse of 25 mod 2^16, and the largest 16-bit multiple of 25 over 25
	localparam logic [15:0] INV25     = 16'd23593;
	localparam logic [15:0] DIV25_MAX = 16'd2621;

	localparam day_t MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// divisible by 400, or by 4 and not by 100
	function automatic logic is_leap(input logic [15:0] year);
		logic [15:0] prod;
		logic        div25;
		prod  = 16'(year * INV25);
		div25 = (prod <= DIV25_MAX);
		return div25 ? (year[3:0] == 4'd0) : (year[1:0] == 2'd0);
	endfunction

	function automatic day_t days_in_month(input month_t month, input logic leap);
		logic [3:0] idx;
		idx = (month >= MONTH_JAN && month <= MONTH_DEC) ? month - 4'd1 : 4'd0;
		if (month == MONTH_FEB && leap) begin
			return DAY_LEAP_FEB;
		end
		return MONTH_LEN[idx];
	endfunction

endpackage

FILE: rtl/calendar_clock_tick.sv
// ----------------------------------------------------------------------------
// calendar_clock_tick
// real-time clock with gregorian calendar, advanced by ticks or loaded by set
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tuser = cmd, s_tdata = set fields
// m_       out  m_tvalid/m_tready   m_tdata = current date and time
//
// one item per cycle while the output is not stalled; an item is captured in
// the input register and its result is then written to the result register
// the result register is the clock state itself, updated only when it moves
// a stalled output holds the input register, s_tready drops once it is full
// reset: 00:00:00 january 1, 2000, both stages empty
// ----------------------------------------------------------------------------
module calendar_clock_tick #(
	parameter int YEAR_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 s_tuser,   // cmd
	// set_second, set_minute, set_hour, set_day, set_month, set_year
	input  logic [((26+YEAR_BITS+7)/8)*8-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year
	output logic [((26+YEAR_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int DATA_BITS = 26 + YEAR_BITS;
	localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;
	localparam logic [YEAR_BITS-1:0] YEAR_MAX     = '1;
	localparam logic [YEAR_BITS-1:0] YEAR_DEFAULT = YEAR_BITS'(cct_pkg::DEFAULT_YEAR);

	logic                   valid_s1;
	logic                   cmd_s1;
	logic [DATA_BITS-1:0]   data_s1;

	cct_pkg::sec_t          sec_q;
	cct_pkg::min_t          min_q;
	cct_pkg::hour_t         hour_q;
	cct_pkg::day_t          day_q;
	cct_pkg::month_t        month_q;
	logic [YEAR_BITS-1:0]   year_q;
	logic                   out_valid_q;

	cct_pkg::sec_t          set_sec;
	cct_pkg::min_t          set_min;
	cct_pkg::hour_t         set_hour;
	cct_pkg::day_t          set_day;
	cct_pkg::month_t        set_month;
	logic [YEAR_BITS-1:0]   set_year;

	cct_pkg::month_t        month_v;
	logic [YEAR_BITS-1:0]   year_v;
	cct_pkg::day_t          dim;

	cct_pkg::sec_t          sec_d;
	cct_pkg::min_t          min_d;
	cct_pkg::hour_t         hour_d;
	cct_pkg::day_t          day_d;
	cct_pkg::month_t        month_d;
	logic [YEAR_BITS-1:0]   year_d;

	logic                   advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			data_s1 <= s_tdata[DATA_BITS-1:0];
		end
	end

	assign set_sec   = data_s1[5:0];
	assign set_min   = data_s1[11:6];
	assign set_hour  = data_s1[16:12];
	assign set_day   = data_s1[21:17];
	assign set_month = data_s1[25:22];
	assign set_year  = data_s1[DATA_BITS-1:26];

	always_comb begin
		if (cmd_s1 == cct_pkg::CMD_SET) begin
			month_v = (set_month >= cct_pkg::MONTH_JAN && set_month <= cct_pkg::MONTH_DEC) ?
				set_month : cct_pkg::MONTH_JAN;
			year_v  = (set_year == '0) ? YEAR_DEFAULT : set_year;
		end else begin
			month_v = month_q;
			year_v  = year_q;
		end
		dim = cct_pkg::days_in_month(month_v, cct_pkg::is_leap(16'(year_v)));

		sec_d   = sec_q;
		min_d   = min_q;
		hour_d  = hour_q;
		day_d   = day_q;
		month_d = month_q;
		year_d  = year_q;

		if (cmd_s1 == cct_pkg::CMD_SET) begin
			sec_d   = (set_sec < cct_pkg::SEC_LIMIT) ? set_sec : '0;
			min_d   = (set_min < cct_pkg::MIN_LIMIT) ? set_min : '0;
			hour_d  = (set_hour < cct_pkg::HOUR_LIMIT) ? set_hour : '0;
			day_d   = (set_day != '0 && set_day <= dim) ? set_day : cct_pkg::DAY_FIRST;
			month_d = month_v;
			year_d  = year_v;
		end else if (sec_q != cct_pkg::SEC_LAST) begin
			sec_d = sec_q + 6'd1;
		end else begin
			sec_d = '0;
			if (min_q != cct_pkg::MIN_LAST) begin
				min_d = min_q + 6'd1;
			end else begin
				min_d = '0;
				if (hour_q != cct_pkg::HOUR_LAST) begin
					hour_d = hour_q + 5'd1;
				end else begin
					hour_d = '0;
					if (day_q < dim) begin
						day_d = day_q + 5'd1;
					end else begin
						day_d = cct_pkg::DAY_FIRST;
						if (month_q < cct_pkg::MONTH_DEC) begin
							month_d = month_q + 4'd1;
						end else begin
							month_d = cct_pkg::MONTH_JAN;
							if (year_q != YEAR_MAX) begin
								year_d = year_q + YEAR_BITS'(1);
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_q       <= '0;
			min_q       <= '0;
			hour_q      <= '0;
			day_q       <= cct_pkg::DAY_FIRST;
			month_q     <= cct_pkg::MONTH_JAN;
			year_q      <= YEAR_DEFAULT;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				sec_q       <= sec_d;
				min_q       <= min_d;
				hour_q      <= hour_d;
				day_q       <= day_d;
				month_q     <= month_d;
				year_q      <= year_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'({year_q, month_q, day_q, hour_q, min_q, sec_q});

endmodule
